>>> rtl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg: shared types and constants for the timestamped price table
// Field widths, default table size and the scan accumulator record.
// ----------------------------------------------------------------------------
package tpt_pkg;

	localparam int FIELD_W         = 31;
	localparam int DEFAULT_ENTRIES = 64;
	localparam int WORD_W          = 2 * FIELD_W;

	typedef logic [FIELD_W-1:0] field_t;

	// running results of one pass over the occupied slots
	typedef struct packed {
		logic   hit;        // a slot holds the incoming stamp
		logic   lat_found;  // a slot holds the newest stamp
		field_t lat_val;    // quote at the newest stamp (after this update)
		logic   any;        // at least one slot seen
		field_t hi;         // largest quote seen
		field_t lo;         // smallest quote seen
	} scan_acc_t;

endpackage

>>> rtl/tpt_ram.sv
// ----------------------------------------------------------------------------
// tpt_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tpt_ram #(
	parameter int WIDTH = tpt_pkg::WORD_W,
	parameter int DEPTH = tpt_pkg::DEFAULT_ENTRIES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/tpt_scan.sv
// ----------------------------------------------------------------------------
// tpt_scan: per-slot compare and min/max unit
// Takes one occupied slot per cycle; finds the key match and the newest
// stamp, and keeps max/min of the quotes as they stand after the update.
// ----------------------------------------------------------------------------
module tpt_scan #(
	parameter int IDX_W = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 en,
	input  logic [IDX_W-1:0]     idx,
	input  tpt_pkg::field_t      e_stamp,
	input  tpt_pkg::field_t      e_quote,
	input  tpt_pkg::field_t      key_stamp,
	input  tpt_pkg::field_t      key_quote,
	input  tpt_pkg::field_t      newest,
	output tpt_pkg::scan_acc_t   acc,
	output logic [IDX_W-1:0]     hit_idx
);

	logic            eq_key;
	logic            eq_new;
	tpt_pkg::field_t eff;
	tpt_pkg::scan_acc_t acc_q;
	logic [IDX_W-1:0]   hit_idx_q;

	// a matching slot already counts with its new quote
	assign eq_key = (e_stamp == key_stamp);
	assign eq_new = (e_stamp == newest);
	assign eff    = eq_key ? key_quote : e_quote;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			hit_idx_q <= '0;
		end else if (clear) begin
			acc_q.hit       <= 1'b0;
			acc_q.lat_found <= 1'b0;
			acc_q.any       <= 1'b0;
		end else if (en) begin
			if (eq_key) begin
				acc_q.hit <= 1'b1;
				hit_idx_q <= idx;
			end
			if (eq_new) begin
				acc_q.lat_found <= 1'b1;
				acc_q.lat_val   <= eff;
			end
			if (!acc_q.any || eff > acc_q.hi) begin
				acc_q.hi <= eff;
			end
			if (!acc_q.any || eff < acc_q.lo) begin
				acc_q.lo <= eff;
			end
			acc_q.any <= 1'b1;
		end
	end

	assign acc     = acc_q;
	assign hit_idx = hit_idx_q;

endmodule

>>> rtl/timestamped_price_table_minmax.sv
// ----------------------------------------------------------------------------
// timestamped_price_table_minmax: keyed price table with latest/max/min
// Stores (stamp, quote) pairs in a RAM, one pass over the table per update.
// ----------------------------------------------------------------------------
//
//  channel | direction | signals                                  | transfer when
//  --------+-----------+------------------------------------------+------------------
//  in      | into      | in_valid, in_ready, stamp, quote         | in_valid & in_ready
//  out     | out of    | out_valid, out_ready, latest_quote,      | out_valid & out_ready
//          |           | highest_quote, lowest_quote, dropped     |
//
//  Pass: after the transfer the occupied slots are read one slot per cycle
//    through the single RAM read port, then the result is loaded and the
//    block returns to idle; a new update is taken only after that.
//  Reset: arst_n clears the fill count, newest stamp and control; no RAM
//    clearing pass, slots at or above the fill count are never read.
//  Stalls: the result sits in an output register; a new update is taken
//    while it waits, and its own result holds in the final state until free.
// ----------------------------------------------------------------------------
module timestamped_price_table_minmax #(
	parameter int TABLE_ENTRIES = tpt_pkg::DEFAULT_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tpt_pkg::FIELD_W-1:0] stamp,
	input  logic [tpt_pkg::FIELD_W-1:0] quote,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tpt_pkg::FIELD_W-1:0] latest_quote,
	output logic [tpt_pkg::FIELD_W-1:0] highest_quote,
	output logic [tpt_pkg::FIELD_W-1:0] lowest_quote,
	output logic                        dropped
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	state_t state_q;

	// update held for the length of the pass
	tpt_pkg::field_t stamp_q;
	tpt_pkg::field_t quote_q;
	tpt_pkg::field_t newest_q;
	logic [CNT_W-1:0] used_q;

	// read sequencing; _s1 lines up with the registered RAM data
	logic [CNT_W-1:0] rd_idx_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic                       in_xfer;
	logic                       issue;
	logic                       slot_free;
	logic                       ram_we;
	logic [IDX_W-1:0]           ram_waddr;
	logic [tpt_pkg::WORD_W-1:0] ram_rdata;
	tpt_pkg::scan_acc_t         acc;
	logic [IDX_W-1:0]           hit_idx;

	logic            full;
	logic            ins;
	logic            drop;
	tpt_pkg::field_t res_latest;
	tpt_pkg::field_t res_hi;
	tpt_pkg::field_t res_lo;
	tpt_pkg::field_t newest_nxt;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign issue     = (state_q == ST_SCAN) && (rd_idx_q < used_q);
	assign slot_free = !out_valid || out_ready;

	// ---- decision once the pass is over ----
	assign full = (used_q == FULL_CNT);
	assign ins  = !acc.hit && !full;
	assign drop = !acc.hit && full;

	always_comb begin
		// a kept update with a stamp at or past the newest one owns the latest slot
		if (!drop && (stamp_q >= newest_q)) begin
			res_latest = quote_q;
		end else if (acc.lat_found) begin
			res_latest = acc.lat_val;
		end else begin
			res_latest = '0;
		end

		// the inserted slot joins max/min; empty table reports zero
		priority if (ins && acc.any) begin
			res_hi = (quote_q > acc.hi) ? quote_q : acc.hi;
			res_lo = (quote_q < acc.lo) ? quote_q : acc.lo;
		end else if (ins) begin
			res_hi = quote_q;
			res_lo = quote_q;
		end else if (acc.any) begin
			res_hi = acc.hi;
			res_lo = acc.lo;
		end else begin
			res_hi = '0;
			res_lo = '0;
		end

		newest_nxt = (!drop && (stamp_q > newest_q)) ? stamp_q : newest_q;
	end

	assign ram_we    = (state_q == ST_WRITE) && slot_free && !drop;
	assign ram_waddr = acc.hit ? hit_idx : used_q[IDX_W-1:0];

	tpt_ram #(
		.WIDTH (tpt_pkg::WORD_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({stamp_q, quote_q}),
		.re    (issue),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	tpt_scan #(
		.IDX_W (IDX_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (in_xfer),
		.en        (rd_vld_s1),
		.idx       (idx_s1),
		.e_stamp   (ram_rdata[tpt_pkg::WORD_W-1:tpt_pkg::FIELD_W]),
		.e_quote   (ram_rdata[tpt_pkg::FIELD_W-1:0]),
		.key_stamp (stamp_q),
		.key_quote (quote_q),
		.newest    (newest_q),
		.acc       (acc),
		.hit_idx   (hit_idx)
	);

	// ---- sequencer, table counters and output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			newest_q  <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			// a new result replaces one leaving in the same cycle
			if (state_q == ST_WRITE && slot_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else if (!rd_vld_s1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (slot_free) begin
						if (ins) begin
							used_q <= used_q + 1'b1;
						end
						newest_q <= newest_nxt;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			stamp_q <= stamp;
			quote_q <= quote;
		end
		if (issue) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (state_q == ST_WRITE && slot_free) begin
			latest_quote  <= res_latest;
			highest_quote <= res_hi;
			lowest_quote  <= res_lo;
			dropped       <= drop;
		end
	end

	// ---- checks ----
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL_CNT)
		else $error("fill count past table size");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dropped) |-> full)
		else $error("update dropped while table had room");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (lowest_quote <= highest_quote))
		else $error("lowest quote above highest quote");

	a_no_write_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> !ram_we)
		else $error("table written during a pass");

endmodule

>>> tb/timestamped_price_table_minmax_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timestamped_price_table_minmax_tb: self-checking bench for the price table
// Drives price updates over a valid/ready channel and scores every report
// (latest, highest and lowest quote, dropped flag) in transfer order. The
// expected reports come from the bench's behavioural table model, or by hand on typed rows.
// There is a short table of directed updates in an empty table, then random
// traffic that fills the table, keeps overwriting keys and runs into the
// full-table drop. Both sides idle at random, and the receiver holds off
// once for long enough to back the block up.
// ----------------------------------------------------------------------------
module timestamped_price_table_minmax_tb;

	typedef tpt_pkg::field_t field_t;

	localparam int   SLOTS       = tpt_pkg::DEFAULT_ENTRIES;
	localparam int   N_RANDOM    = 890;
	localparam int   IDLE_PCT    = 15;
	// window (by transfer count) in which neither side idles
	localparam int   QUIET_FROM  = 400;
	localparam int   QUIET_TO    = 550;
	// receiver hold-off: starts after this many reports, lasts this many cycles
	localparam int   HOLD_AFTER  = 250;
	localparam int   HOLD_CYCLES = 300;
	localparam field_t F_MAX     = 31'h7FFF_FFFF;

	// one report as it leaves the block
	typedef struct packed {
		field_t latest;
		field_t highest;
		field_t lowest;
		logic   dropped;
	} quote_report_t;

	// one directed update; a typed row carries its report written out by hand
	typedef struct {
		field_t        stamp;
		field_t        quote;
		bit            typed;
		quote_report_t report;
	} update_row_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	field_t stamp;
	field_t quote;
	logic   out_valid;
	logic   out_ready;
	field_t latest_quote;
	field_t highest_quote;
	field_t lowest_quote;
	logic   dropped;

	// bench copy of the table: slots fill from 0 upward and are never freed
	field_t tbl_stamp [SLOTS];
	field_t tbl_quote [SLOTS];
	int     tbl_fill;
	field_t newest_seen;

	quote_report_t pending_reports[$];
	update_row_t   update_rows[$];

	int  fail_count;
	int  reports_seen;
	int  updates_sent;
	int  drops_predicted;
	bit  sender_done;

	timestamped_price_table_minmax #(
		.TABLE_ENTRIES(SLOTS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.stamp        (stamp),
		.quote        (quote),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.latest_quote (latest_quote),
		.highest_quote(highest_quote),
		.lowest_quote (lowest_quote),
		.dropped      (dropped)
	);

	// ------------------------------------------------------------------
	// clock, reset, watchdog
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// fails the run if it has not finished by this time
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// table model: apply one update, return the report it should produce
	// ------------------------------------------------------------------
	function automatic quote_report_t apply_update(field_t st, field_t qt);
		quote_report_t rep;
		bit            hit;
		bit            seen;
		rep  = '0;
		hit  = 1'b0;
		seen = 1'b0;
		// keys are unique, so at most one slot matches
		for (int i = 0; i < tbl_fill; i++) begin
			if (!hit && tbl_stamp[i] == st) begin
				tbl_quote[i] = qt;
				hit          = 1'b1;
			end
		end
		if (!hit) begin
			if (tbl_fill < SLOTS) begin
				tbl_stamp[tbl_fill] = st;
				tbl_quote[tbl_fill] = qt;
				tbl_fill++;
			end else begin
				rep.dropped = 1'b1;
			end
		end
		// a dropped update never advances the newest stamp
		if (!rep.dropped && st > newest_seen)
			newest_seen = st;
		for (int i = 0; i < tbl_fill; i++) begin
			if (tbl_stamp[i] == newest_seen)
				rep.latest = tbl_quote[i];
			if (!seen || tbl_quote[i] > rep.highest)
				rep.highest = tbl_quote[i];
			if (!seen || tbl_quote[i] < rep.lowest)
				rep.lowest = tbl_quote[i];
			seen = 1'b1;
		end
		return rep;
	endfunction

	// ------------------------------------------------------------------
	// random stimulus
	// ------------------------------------------------------------------
	// mostly fresh keys and keys already stored, plus edge keys and a small
	// cluster near zero that collides often
	function automatic field_t pick_stamp();
		int     r;
		field_t st;
		r  = $urandom_range(99);
		st = field_t'($urandom);
		if (r < 40) begin
			st = field_t'($urandom);
		end else if (r < 85) begin
			if (tbl_fill > 0)
				st = tbl_stamp[$urandom_range(tbl_fill - 1)];
		end else if (r < 92) begin
			st = $urandom_range(1) ? F_MAX : '0;
		end else begin
			st = field_t'($urandom_range(16));
		end
		return st;
	endfunction

	function automatic field_t pick_quote();
		int     r;
		field_t qt;
		r  = $urandom_range(99);
		qt = field_t'($urandom);
		if (r >= 85) begin
			case ($urandom_range(3))
				0:       qt = '0;
				1:       qt = 31'd1;
				2:       qt = F_MAX - 31'd1;
				default: qt = F_MAX;
			endcase
		end else if (r >= 70) begin
			qt = field_t'($urandom_range(255));
		end
		return qt;
	endfunction

	task automatic add_row(field_t st, field_t qt, bit typed,
			field_t lat, field_t hi, field_t lo, logic drp);
		update_row_t row;
		row.stamp  = st;
		row.quote  = qt;
		row.typed  = typed;
		row.report = '{latest: lat, highest: hi, lowest: lo, dropped: drp};
		update_rows.push_back(row);
	endtask

	// ------------------------------------------------------------------
	// sender: directed rows, then random updates; drives on the falling edge
	// ------------------------------------------------------------------
	initial begin : sender
		int            total;
		field_t        st;
		field_t        qt;
		bit            typed;
		quote_report_t hand_report;
		quote_report_t model_report;

		in_valid    = 1'b0;
		stamp       = '0;
		quote       = '0;
		sender_done = 1'b0;
		tbl_fill    = 0;
		newest_seen = '0;

		// zero stamp into an empty table matches the reset newest stamp
		add_row('0,              31'd5,          1, 31'd5, 31'd5, 31'd5, 1'b0);
		add_row(F_MAX,           F_MAX,          1, F_MAX, F_MAX, 31'd5, 1'b0);
		add_row(31'd1,           '0,             1, F_MAX, F_MAX, '0,    1'b0);
		// overwrite the newest key, then an older one
		add_row(F_MAX,           31'd1,          0, '0, '0, '0, 1'b0);
		add_row(31'd1,           F_MAX,          0, '0, '0, '0, 1'b0);
		add_row(31'h2AAA_AAAA,   31'h5555_5555,  0, '0, '0, '0, 1'b0);
		add_row(31'h5555_5555,   31'h2AAA_AAAA,  0, '0, '0, '0, 1'b0);
		add_row('0,              '0,             0, '0, '0, '0, 1'b0);
		add_row(31'h2AAA_AAAA,   31'h2AAA_AAAA,  0, '0, '0, '0, 1'b0);
		add_row(31'h4000_0000,   31'h4000_0000,  0, '0, '0, '0, 1'b0);
		// same key twice in a row
		add_row(31'd3,           31'd1,          0, '0, '0, '0, 1'b0);
		add_row(31'd3,           31'd3,          0, '0, '0, '0, 1'b0);
		// two more overwrites; the second replaces the old maximum
		add_row(F_MAX,           31'd7,          0, '0, '0, '0, 1'b0);
		add_row(31'd1,           31'd9,          0, '0, '0, '0, 1'b0);

		wait (arst_n === 1'b1);
		@(negedge clk);

		total = update_rows.size() + N_RANDOM;
		for (int k = 0; k < total; k++) begin
			if (k < update_rows.size()) begin
				st          = update_rows[k].stamp;
				qt          = update_rows[k].quote;
				typed       = update_rows[k].typed;
				hand_report = update_rows[k].report;
			end else begin
				st    = pick_stamp();
				qt    = pick_quote();
				typed = 1'b0;
			end

			if (k < QUIET_FROM || k >= QUIET_TO) begin
				while ($urandom_range(99) < IDLE_PCT) begin
					in_valid = 1'b0;
					@(negedge clk);
				end
			end

			in_valid = 1'b1;
			stamp    = st;
			quote    = qt;
			do
				@(posedge clk);
			while (!in_ready);

			// transfer taken at this edge
			model_report = apply_update(st, qt);
			pending_reports.push_back(typed ? hand_report : model_report);
			if (model_report.dropped)
				drops_predicted++;
			updates_sent++;
			@(negedge clk);
		end
		in_valid    = 1'b0;
		sender_done = 1'b1;
	end

	// ------------------------------------------------------------------
	// receiver: random back-pressure, one long hold-off, a quiet window
	// ------------------------------------------------------------------
	initial begin : receiver
		bit held;
		held      = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held && reports_seen >= HOLD_AFTER) begin
				// sender keeps offering meanwhile, so the input side stalls too
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end else if (reports_seen >= QUIET_FROM && reports_seen < QUIET_TO) begin
				out_ready = 1'b1;
			end else begin
				out_ready = ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// ------------------------------------------------------------------
	// scoreboard: each report against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		quote_report_t want;
		if (arst_n && out_valid && out_ready) begin
			reports_seen <= reports_seen + 1;
			if (pending_reports.size() == 0) begin
				$error("stray report: latest %h high %h low %h drop %b",
					latest_quote, highest_quote, lowest_quote, dropped);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				if (latest_quote !== want.latest) begin
					$error("latest_quote: expected %h, got %h", want.latest, latest_quote);
					fail_count++;
				end
				if (highest_quote !== want.highest) begin
					$error("highest_quote: expected %h, got %h", want.highest, highest_quote);
					fail_count++;
				end
				if (lowest_quote !== want.lowest) begin
					$error("lowest_quote: expected %h, got %h", want.lowest, lowest_quote);
					fail_count++;
				end
				if (dropped !== want.dropped) begin
					$error("dropped: expected %b, got %b", want.dropped, dropped);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// end of run
	// ------------------------------------------------------------------
	initial begin : finisher
		fail_count      = 0;
		reports_seen    = 0;
		updates_sent    = 0;
		drops_predicted = 0;
		wait (sender_done);
		while (pending_reports.size() != 0)
			@(posedge clk);
		// let any stray report surface: one full scan plus margin
		repeat (SLOTS + 8) @(posedge clk);
		if (pending_reports.size() != 0) begin
			$error("%0d reports never arrived", pending_reports.size());
			fail_count++;
		end
		$display("Covered %0d updates (%0d directed); table filled %0d of %0d slots,",
			updates_sent, update_rows.size(), tbl_fill, SLOTS);
		$display("%0d drops on a full table; scored %0d reports under back-pressure, %0d mismatches.",
			drops_predicted, reports_seen, fail_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
